>>> design/cdd_pkg.sv
// Shared types, constants and the month_start function for the calendar date difference pipeline.
// No dependencies.
package cdd_pkg;

   localparam int unsigned YEAR_W      = 12;
   localparam int unsigned MONTH_W     = 4;
   localparam int unsigned DAY_W       = 5;
   localparam int unsigned YEXT_W      = 13;
   localparam int unsigned MSTART_W    = 9;
   localparam int unsigned DNUM_W      = 21;
   localparam int unsigned DIFF_W      = 21;
   localparam int unsigned RECIP_W     = 11;
   localparam int unsigned RECIP_SHIFT = 15;

   localparam logic [YEXT_W-1:0]  YEAR_OFFSET = 13'd400;
   localparam logic [RECIP_W-1:0] RECIP_25    = 11'd1311;   // 2^15 / 25, rounded up
   localparam logic [8:0]         DAYS_YEAR   = 9'd365;
   localparam logic [4:0]         DIV_25      = 5'd25;
   localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;

   localparam logic signed [DIFF_W+1:0] DIFF_MAX = 23'sd1048575;
   localparam logic signed [DIFF_W+1:0] DIFF_MIN = -23'sd1048576;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

   // days before the first of the month, common year; 0 as Jan, 13..15 as Dec
   function automatic logic [MSTART_W-1:0] month_start(input logic [MONTH_W-1:0] m);
      logic [MSTART_W-1:0] r;
      case (m)
         4'd0, 4'd1: r = 9'd0;
         4'd2:       r = 9'd31;
         4'd3:       r = 9'd59;
         4'd4:       r = 9'd90;
         4'd5:       r = 9'd120;
         4'd6:       r = 9'd151;
         4'd7:       r = 9'd181;
         4'd8:       r = 9'd212;
         4'd9:       r = 9'd243;
         4'd10:      r = 9'd273;
         4'd11:      r = 9'd304;
         default:    r = 9'd334;
      endcase
      return r;
   endfunction

endpackage

>>> design/calendar_date_difference_days_top.sv
// Each accepted word passes through the day number stages s1, s2 and s3, then the result register.
// Throughput: one word per cycle while the output is not stalled; two day number units run side by side.
// Each stage stalls only when full and the one after it is blocked.
// Reset (synchronous) clears all valid bits; payload registers are not reset.
// Depends on cdd_pkg and cdd_day_number.
module calendar_date_difference_days_top
   import cdd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // first_year, first_month, first_day, second_year, second_month, second_day, pad
   input  logic [47:0] req_tdata,
   // include_end
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // day_difference, pad
   output logic [23:0] rsp_tdata
);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;
   logic inc1_ff, inc2_ff, inc3_ff, inc4_ff;
   stage_en_type en;
   logic [DNUM_W-1:0] dn_a, dn_b;
   logic signed [DIFF_W+1:0] diff, adj;
   logic [DIFF_W-1:0] res_ff, res_in;

   assign rdy4 = !v4_ff || rsp_tready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign en = '{s1: rdy1, s2: rdy2, s3: rdy3};

   cdd_day_number u_first (
      .clock   (clock),
      .en      (en),
      .year    (req_tdata[11:0]),
      .month   (req_tdata[15:12]),
      .day     (req_tdata[20:16]),
      .day_num (dn_a)
   );

   cdd_day_number u_second (
      .clock   (clock),
      .en      (en),
      .year    (req_tdata[32:21]),
      .month   (req_tdata[36:33]),
      .day     (req_tdata[41:37]),
      .day_num (dn_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) inc1_ff <= req_tuser;
      if (rdy2) inc2_ff <= inc1_ff;
      if (rdy3) inc3_ff <= inc2_ff;
   end

   assign diff = $signed({2'b00, dn_b}) - $signed({2'b00, dn_a});
   assign adj  = !inc3_ff ? diff : ((diff >= 0) ? diff + 23'sd1 : diff - 23'sd1);

   always_comb begin
      if (adj > DIFF_MAX) begin
         res_in = DIFF_MAX[DIFF_W-1:0];
      end else if (adj < DIFF_MIN) begin
         res_in = DIFF_MIN[DIFF_W-1:0];
      end else begin
         res_in = adj[DIFF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         res_ff  <= res_in;
         inc4_ff <= inc3_ff;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {3'b000, res_ff};

   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v1_ff)
      else $error("accepted word did not enter stage 1");

   a_s3_holds: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !rdy3) |=> (v3_ff && $stable(dn_a) && $stable(dn_b)))
      else $error("stage 3 lost or changed its word under stall");

   a_inc_nonzero: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && inc4_ff) |-> (res_ff != '0))
      else $error("include_end result is zero");

endmodule

>>> design/cdd_day_number.sv
// Three-stage day number unit: converts one date to a linear day count.
// Depends on cdd_pkg.
module cdd_day_number
   import cdd_pkg::*;
(
   input  logic                clock,
   input  stage_en_type        en,
   input  logic [YEAR_W-1:0]   year,
   input  logic [MONTH_W-1:0]  month,
   input  logic [DAY_W-1:0]    day,
   output logic [DNUM_W-1:0]   day_num
);

   // stage 1
   logic [YEXT_W-1:0]   y1_ff, y1_in, prev1_ff, prev1_in;
   logic [MSTART_W-1:0] ms1_ff;
   logic                late1_ff;
   logic [DAY_W-1:0]    d1_ff;

   // stage 2
   logic [DNUM_W-1:0]   p365_ff, p365_in;
   logic [10:0]         q4_ff;
   logic [21:0]         r100_ff, r100_in;
   logic [19:0]         r400_ff, r400_in;
   logic [23:0]         r25_ff, r25_in;
   logic [YEXT_W-1:0]   y2_ff;
   logic [MSTART_W-1:0] ms2_ff;
   logic                late2_ff;
   logic [DAY_W-1:0]    d2_ff;

   // stage 3
   logic [6:0]          q100;
   logic [4:0]          q400;
   logic [8:0]          q25;
   logic [YEXT_W-1:0]   rem_full;
   logic                leap;
   logic [DNUM_W-1:0]   dn_ff, dn_in;

   assign y1_in   = {1'b0, year} + YEAR_OFFSET;
   assign prev1_in = y1_in - 13'd1;

   always_ff @(posedge clock) begin
      if (en.s1) begin
         y1_ff    <= y1_in;
         prev1_ff <= prev1_in;
         ms1_ff   <= month_start(month);
         late1_ff <= (month > MONTH_FEB);
         d1_ff    <= day;
      end
   end

   assign p365_in = DNUM_W'(prev1_ff * DAYS_YEAR);
   assign r100_in = prev1_ff[12:2] * RECIP_25;
   assign r400_in = prev1_ff[12:4] * RECIP_25;
   assign r25_in  = y1_ff * RECIP_25;

   always_ff @(posedge clock) begin
      if (en.s2) begin
         p365_ff  <= p365_in;
         q4_ff    <= prev1_ff[12:2];
         r100_ff  <= r100_in;
         r400_ff  <= r400_in;
         r25_ff   <= r25_in;
         y2_ff    <= y1_ff;
         ms2_ff   <= ms1_ff;
         late2_ff <= late1_ff;
         d2_ff    <= d1_ff;
      end
   end

   assign q100     = r100_ff[21:RECIP_SHIFT];
   assign q400     = r400_ff[19:RECIP_SHIFT];
   assign q25      = r25_ff[23:RECIP_SHIFT];
   assign rem_full = y2_ff - YEXT_W'(q25 * DIV_25);
   // century years are leap only when divisible by 16 as well (i.e. by 400)
   assign leap     = (y2_ff[1:0] == 2'd0) &&
                     ((rem_full[4:0] != 5'd0) || (y2_ff[3:0] == 4'd0));

   assign dn_in = p365_ff + DNUM_W'(q4_ff) - DNUM_W'(q100) + DNUM_W'(q400)
                + DNUM_W'(ms2_ff) + DNUM_W'(leap && late2_ff) + DNUM_W'(d2_ff);

   always_ff @(posedge clock) begin
      if (en.s3) begin
         dn_ff <= dn_in;
      end
   end

   assign day_num = dn_ff;

endmodule
